// ===== src/tksi_pkg.sv =====
// Shared constants, request/response types and operation codes for the top-k list.
`timescale 1ns / 1ps
`default_nettype none
package tksi_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int TAG_BITS    = 16;
	localparam int SCORE_BITS  = 32;
	localparam int RANK_BITS   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int COUNT_BITS  = $clog2(MAX_ENTRIES + 1);
	localparam int CAP_BITS    = 5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_READ   = 1'b1;

	typedef struct packed {
		logic                         operation;
		logic [TAG_BITS-1:0]          entry_tag;
		logic signed [SCORE_BITS-1:0] entry_score;
		logic [RANK_BITS-1:0]         read_rank;
	} req_t;

	typedef struct packed {
		logic                         out_valid;
		logic [TAG_BITS-1:0]          out_tag;
		logic signed [SCORE_BITS-1:0] out_score;
		logic [RANK_BITS-1:0]         placed_rank;
		logic                         dropped;
		logic [COUNT_BITS-1:0]        entry_count;
	} rsp_t;

	// Broadcast control from the top level to every rank cell.
	typedef struct packed {
		logic ins_en;    // insert accepted this cycle
		logic top;       // new entry goes to rank 0
		logic in_range;  // this cell's rank is below the held count
		logic first;     // this cell is rank 0
	} cell_ctl_t;

endpackage
`default_nettype wire

// ===== src/tksi_cell.sv =====
// One rank cell: holds an entry, compares it with the new score and shifts down.
`timescale 1ns / 1ps
`default_nettype none
module tksi_cell
	import tksi_pkg::*;
(
	input  wire logic                         clk,
	input  wire cell_ctl_t                    ctl,
	input  wire logic [TAG_BITS-1:0]          new_tag,
	input  wire logic signed [SCORE_BITS-1:0] new_score,
	input  wire logic                         prev_after,
	input  wire logic [TAG_BITS-1:0]          prev_tag,
	input  wire logic signed [SCORE_BITS-1:0] prev_score,
	output logic                              after,
	output logic [TAG_BITS-1:0]               tag_q,
	output logic signed [SCORE_BITS-1:0]      score_q
);

	logic ge;

	// A cell past the held entries, or one not above the new score, is a landing spot.
	assign ge    = !ctl.in_range || !(score_q > new_score);
	assign after = ctl.top || (ge && !ctl.first);

	always_ff @(posedge clk) begin
		if (ctl.ins_en) begin
			if (prev_after) begin
				tag_q   <= prev_tag;
				score_q <= prev_score;
			end else if (after) begin
				tag_q   <= new_tag;
				score_q <= new_score;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/top_k_sorted_insert.sv =====
// Top level of the top-k sorted list: request/response channels, config and cell chain.
//
// Usage:
//   Requests arrive on req with req_valid/req_stall; a request is taken at a
//   clock edge where req_valid is high and req_stall is low. Operation insert
//   places (entry_tag, entry_score) in the descending-score list; operation
//   read returns the entry at read_rank.
//   Each request yields exactly one response on rsp with rsp_valid/rsp_stall,
//   in the cycle after it is taken, from an output register.
//   Throughput is one request per cycle while responses are not stalled: all
//   rank cells compare the new score in parallel and shift in the same edge,
//   so the next request sees the updated list.
//   When the receiver stalls, the response register holds and req_stall rises
//   once it is full; a new request is taken in the same cycle the held
//   response is taken.
//   The capacity register is written through cfg_valid/cfg_ready/cfg_data;
//   cfg_ready is always high.
//   Reset empties the list (held count zero), sets capacity to the maximum and
//   empties the response register. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module top_k_sorted_insert
	import tksi_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire req_t                req,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output rsp_t                     rsp,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CAP_BITS-1:0] cfg_data
);

	logic [CAP_BITS-1:0]   cap_q;
	logic [COUNT_BITS-1:0] held_q;
	logic                  rsp_full_q;
	rsp_t                  rsp_q;

	logic                  take;
	logic                  ins_en;
	logic                  top;
	logic [COUNT_BITS-1:0] kept;
	logic [COUNT_BITS:0]   grow;
	logic [COUNT_BITS-1:0] count_nxt;
	logic [COUNT_BITS-1:0] pos;
	logic                  drop;
	logic                  rd_hit;
	rsp_t                  rsp_d;

	logic [MAX_ENTRIES-1:0]        after;
	logic [TAG_BITS-1:0]           cell_tag   [MAX_ENTRIES];
	logic signed [SCORE_BITS-1:0]  cell_score [MAX_ENTRIES];

	// Take a new request whenever the response register is free or drains now.
	assign req_stall = rsp_full_q && rsp_stall;
	assign take      = req_valid && !req_stall;
	assign ins_en    = take && (req.operation == OP_INSERT);
	assign cfg_ready = 1'b1;

	// Capacity: zero acts as one, anything above the maximum acts as the maximum.
	always_comb begin
		if (cap_q == '0) begin
			kept = COUNT_BITS'(1);
		end else if (32'(cap_q) > MAX_ENTRIES) begin
			kept = COUNT_BITS'(MAX_ENTRIES);
		end else begin
			kept = COUNT_BITS'(cap_q);
		end
	end

	assign grow      = {1'b0, held_q} + (COUNT_BITS+1)'(1);
	assign count_nxt = (grow > {1'b0, kept}) ? kept : grow[COUNT_BITS-1:0];

	// Strictly above rank 0 (or empty list) lands at the top; a tie with rank 0 lands after it.
	assign top = (held_q == '0) || (req.entry_score > cell_score[0]);

	genvar gi;
	generate
		for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
			cell_ctl_t ctl;
			logic                         p_after;
			logic [TAG_BITS-1:0]          p_tag;
			logic signed [SCORE_BITS-1:0] p_score;

			assign ctl.ins_en   = ins_en;
			assign ctl.top      = top;
			assign ctl.in_range = (32'(gi) < 32'(held_q));
			assign ctl.first    = (gi == 0);

			if (gi == 0) begin : g_head
				assign p_after = 1'b0;
				assign p_tag   = req.entry_tag;
				assign p_score = req.entry_score;
			end else begin : g_link
				assign p_after = after[gi-1];
				assign p_tag   = cell_tag[gi-1];
				assign p_score = cell_score[gi-1];
			end

			tksi_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.new_tag    (req.entry_tag),
				.new_score  (req.entry_score),
				.prev_after (p_after),
				.prev_tag   (p_tag),
				.prev_score (p_score),
				.after      (after[gi]),
				.tag_q      (cell_tag[gi]),
				.score_q    (cell_score[gi])
			);
		end
	endgenerate

	// The landing flags are monotone along the chain, so the rank is the count of cells before it.
	assign pos    = COUNT_BITS'($countones(~after));
	assign drop   = (pos >= count_nxt);
	assign rd_hit = ({{(COUNT_BITS+1-RANK_BITS){1'b0}}, req.read_rank} < {1'b0, held_q});

	always_comb begin
		rsp_d = '0;
		if (req.operation == OP_READ) begin
			rsp_d.entry_count = held_q;
			if (rd_hit) begin
				rsp_d.out_valid = 1'b1;
				rsp_d.out_tag   = cell_tag[req.read_rank];
				rsp_d.out_score = cell_score[req.read_rank];
			end
		end else begin
			rsp_d.entry_count = count_nxt;
			rsp_d.dropped     = drop;
			rsp_d.placed_rank = drop ? '0 : pos[RANK_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q      <= CAP_BITS'(MAX_ENTRIES);
			held_q     <= '0;
			rsp_full_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (ins_en) begin
				held_q <= count_nxt;
			end
			// Fill on a new request, drop the flag when the held response leaves.
			if (take) begin
				rsp_full_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_full_q <= 1'b0;
			end
		end
	end

	// Response payload: advance only with a new request, hold while stalled.
	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_full_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

// ===== dv/tksi_rank_checker.sv =====
// Checker for the top-k list: tracks requests, predicts each response and compares it.
`timescale 1ns / 1ps
module tksi_rank_checker
	import tksi_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_stall,
	input  req_t                req,
	input  logic                rsp_valid,
	input  logic                rsp_stall,
	input  rsp_t                rsp,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [CAP_BITS-1:0] cfg_data,
	output int                  mismatches,
	output int                  outstanding
);

	// Own copy of the ranked list and the capacity register.
	logic signed [SCORE_BITS-1:0] ranked_score [MAX_ENTRIES];
	logic [TAG_BITS-1:0]          ranked_tag   [MAX_ENTRIES];
	int                           kept = 0;
	logic [CAP_BITS-1:0]          cap_setting = CAP_BITS'(MAX_ENTRIES);

	rsp_t rsp_due [$];

	initial mismatches = 0;

	// Insert or read one request against the list; return the response it causes.
	function automatic rsp_t apply_to_list(input req_t r);
		rsp_t o;
		int   limit;
		int   pos;
		int   count;
		o = '0;
		if (r.operation == OP_READ) begin
			if (int'(r.read_rank) < kept) begin
				o.out_valid = 1'b1;
				o.out_tag   = ranked_tag[r.read_rank];
				o.out_score = ranked_score[r.read_rank];
			end
		end else begin
			if (cap_setting < 1)
				limit = 1;
			else if (cap_setting > MAX_ENTRIES)
				limit = MAX_ENTRIES;
			else
				limit = int'(cap_setting);
			// a tie with the top entry lands just after it
			if (kept == 0 || r.entry_score > ranked_score[0]) begin
				pos = 0;
			end else begin
				pos = 1;
				while (pos < kept && ranked_score[pos] > r.entry_score)
					pos++;
			end
			count = (kept + 1 > limit) ? limit : kept + 1;
			if (pos < count) begin
				for (int i = count - 1; i > pos; i--) begin
					ranked_score[i] = ranked_score[i-1];
					ranked_tag[i]   = ranked_tag[i-1];
				end
				ranked_score[pos] = r.entry_score;
				ranked_tag[pos]   = r.entry_tag;
				o.placed_rank     = RANK_BITS'(pos);
			end else begin
				o.dropped = 1'b1;
			end
			kept = count;
		end
		o.entry_count = COUNT_BITS'(kept);
		return o;
	endfunction

	task automatic compare_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			kept        = 0;
			cap_setting = CAP_BITS'(MAX_ENTRIES);
			rsp_due.delete();
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				cap_setting = cfg_data;
			if (rsp_valid && !rsp_stall) begin
				if (rsp_due.size() == 0) begin
					$error("response with no request waiting");
					mismatches++;
				end else begin
					want = rsp_due.pop_front();
					compare_field("out_valid", 64'(want.out_valid), 64'(rsp.out_valid));
					compare_field("out_tag", 64'(want.out_tag), 64'(rsp.out_tag));
					compare_field("out_score", 64'(unsigned'(want.out_score)),
						64'(unsigned'(rsp.out_score)));
					compare_field("placed_rank", 64'(want.placed_rank),
						64'(rsp.placed_rank));
					compare_field("dropped", 64'(want.dropped), 64'(rsp.dropped));
					compare_field("entry_count", 64'(want.entry_count),
						64'(rsp.entry_count));
				end
			end
			if (req_valid && !req_stall)
				rsp_due.push_back(apply_to_list(req));
			outstanding = rsp_due.size();
		end
	end

endmodule

// ===== dv/tb_top_k_sorted_insert.sv =====
// Testbench top for the top-k sorted list: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top_k_sorted_insert;
	import tksi_pkg::*;

	// Watchdog bound, set far above the slowest run, before calling it hung.
	localparam int CYCLE_LIMIT = 200_000;
	// Length of the receiver hold-off that fills the block and stalls its input.
	localparam int HOLD_CYCLES = 60;
	// Cycles to wait after the last response before a register write or the end.
	localparam int SETTLE_CYCLES = 4;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	req_t                req;
	logic                rsp_valid;
	logic                rsp_stall;
	rsp_t                rsp;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CAP_BITS-1:0] cfg_data;

	int mismatches;
	int outstanding;
	int cycles = 0;

	// Idle rates in percent per cycle, set per phase by the stimulus process.
	int send_idle_pct = 0;
	int stall_pct     = 0;
	// Hold-off handshake: the stimulus bumps hold_asked, the receiver serves it.
	int hold_asked  = 0;
	int hold_served = 0;
	int hold_left   = 0;

	always #5 clk = ~clk;

	top_k_sorted_insert DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	tksi_rank_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Watchdog: end the run if the handshakes hang.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[top_k_sorted_insert] ERROR");
			$finish;
		end
	end

	// Receiver: stall at random at the phase rate, or hold off for a long
	// stretch when the stimulus asks, one stall decision per falling edge.
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_asked) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Offer one request; enter and leave at a falling edge with valid still high,
	// so back-to-back requests never lower and raise valid in the same step.
	task automatic send_request(input req_t r);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req       <= r;
		req_valid <= 1'b1;
		// hold the request until an edge takes it
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic insert_entry(input logic [TAG_BITS-1:0] tag,
			input logic signed [SCORE_BITS-1:0] score);
		req_t r;
		r             = '0;
		r.operation   = OP_INSERT;
		r.entry_tag   = tag;
		r.entry_score = score;
		send_request(r);
	endtask

	task automatic read_entry(input logic [RANK_BITS-1:0] rank);
		req_t r;
		r           = '0;
		r.operation = OP_READ;
		r.read_rank = rank;
		send_request(r);
	endtask

	// Write capacity only once the block is idle: drop valid, drain every
	// response, wait the settle time, then do the single write.
	task automatic write_capacity(input logic [CAP_BITS-1:0] value);
		req_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Scores: full range, a narrow band near zero for ties, a wider band around zero, and the extremes.
	function automatic logic signed [SCORE_BITS-1:0] pick_score();
		case ($urandom_range(3))
			0: return SCORE_BITS'($urandom);
			1: return SCORE_BITS'(int'($urandom_range(7)) - 4);
			2: begin
				case ($urandom_range(3))
					0: return 32'sh7FFF_FFFF;
					1: return 32'sh8000_0000;
					2: return -32'sd1;
					default: return 32'sd0;
				endcase
			end
			default: return SCORE_BITS'(int'($urandom_range(1000)) - 500);
		endcase
	endfunction

	function automatic logic [CAP_BITS-1:0] pick_capacity();
		case ($urandom_range(4))
			0: return CAP_BITS'(MAX_ENTRIES);
			1: return CAP_BITS'(1);
			2: return CAP_BITS'($urandom_range(31));
			default: return CAP_BITS'($urandom_range(8, 2));
		endcase
	endfunction

	// Random mix of inserts and reads; read fields of an insert carry noise too.
	task automatic run_random(input int n);
		req_t r;
		for (int i = 0; i < n; i++) begin
			r.operation   = ($urandom_range(99) < 60) ? OP_INSERT : OP_READ;
			r.entry_tag   = TAG_BITS'($urandom);
			r.entry_score = pick_score();
			r.read_rank   = RANK_BITS'($urandom);
			send_request(r);
		end
	endtask

	// One idle setting, several capacity segments; optionally squeeze the
	// block with a long receiver hold-off while requests keep coming.
	task automatic run_phase(input int send_idle, input int recv_idle, input bit squeeze);
		send_idle_pct = send_idle;
		stall_pct     = recv_idle;
		for (int s = 0; s < 4; s++) begin
			write_capacity(pick_capacity());
			if (squeeze && s == 1)
				hold_asked++;
			run_random(100 + $urandom_range(10));
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		send_idle_pct = 30;
		stall_pct     = 68;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty read, ties at and below the top, score extremes.
		read_entry(4'd0);
		insert_entry(16'h0000, 32'sd0);
		insert_entry(16'hFFFF, 32'sd0);           // tie with top, lands after it
		insert_entry(16'h1234, 32'sh7FFF_FFFF);
		insert_entry(16'hABCD, 32'sh8000_0000);
		insert_entry(16'h5555, 32'sd0);           // tie below top, goes ahead
		insert_entry(16'hAAAA, 32'sh7FFF_FFFF);   // tie with top again
		insert_entry(16'h0F0F, -32'sd1);
		for (int i = 0; i < 7; i++)
			read_entry(RANK_BITS'(i));
		read_entry(4'd15);                        // past the held entries

		// Lower the capacity while entries are held: reads still see them
		// until the next insert cuts the list.
		write_capacity(5'd2);
		read_entry(4'd5);
		insert_entry(16'h3C3C, 32'sh8000_0000);   // ranks below, dropped
		read_entry(4'd2);

		// Zero capacity acts as one; a tie with the top is then dropped.
		write_capacity(5'd0);
		insert_entry(16'hC3C3, 32'sh7FFF_FFFF);
		read_entry(4'd0);

		// Capacity above the maximum acts as the maximum.
		write_capacity(5'd31);
		insert_entry(16'h8001, 32'sd7);
		read_entry(4'd1);

		run_phase(30, 68, 1'b0);
		run_phase(68, 30, 1'b0);
		run_phase(0, 0, 1'b1);

		// Drain and settle before the verdict.
		req_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (mismatches == 0)
			$display("[top_k_sorted_insert] OK");
		else
			$display("[top_k_sorted_insert] ERROR");
		$finish;
	end

endmodule
